// ===== src/pcfc_pkg.sv =====
// Package for the parallel camera frame capture block.
// Phase encoding, result and error codes, register indexes, frame geometry.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package pcfc_pkg;

    // frame geometry
    localparam int FRAME_WIDTH      = 160;
    localparam int FRAME_HEIGHT     = 120;
    localparam int PIXELS_PER_FRAME = FRAME_WIDTH * FRAME_HEIGHT;

    // limit registers
    localparam int LIMIT_W = 24;
    localparam logic [LIMIT_W-1:0] VSYNC_LIMIT_RST = 24'd100000;
    localparam logic [LIMIT_W-1:0] ROW_LIMIT_RST   = 24'd1000000;
    localparam logic [LIMIT_W-1:0] CLOCK_LIMIT_RST = 24'd100000;

    typedef logic [1:0]         t_cfg_idx;
    typedef logic [LIMIT_W-1:0] t_limit;

    localparam t_cfg_idx CFG_VSYNC_LIMIT = 2'd0;
    localparam t_cfg_idx CFG_ROW_LIMIT   = 2'd1;
    localparam t_cfg_idx CFG_CLOCK_LIMIT = 2'd2;

    // payload types
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_pixel;
    typedef logic [14:0] t_index;
    typedef logic [7:0]  t_column;
    typedef logic [6:0]  t_row;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PIXEL = 2'd0;
    localparam t_kind KIND_DONE  = 2'd1;
    localparam t_kind KIND_ERROR = 2'd2;

    typedef logic [2:0] t_err_code;
    localparam t_err_code ERR_VSYNC_LOW = 3'd0;
    localparam t_err_code ERR_VSYNC_HIGH = 3'd1;
    localparam t_err_code ERR_HREF_LOW  = 3'd2;
    localparam t_err_code ERR_HREF_HIGH = 3'd3;
    localparam t_err_code ERR_PCLK_HIGH = 3'd4;
    localparam t_err_code ERR_PCLK_LOW  = 3'd5;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_VS_HIGH   = 4'd1,
        PH_VS_LOW    = 4'd2,
        PH_HREF_HIGH = 4'd3,
        PH_CLK_LO_A  = 4'd4,
        PH_CLK_HI_A  = 4'd5,
        PH_CLK_LO_B  = 4'd6,
        PH_CLK_HI_B  = 4'd7,
        PH_HREF_LOW  = 4'd8
    } t_phase;

endpackage

// ===== src/pcfc_if.sv =====
// Valid/ready channel interfaces for the camera capture block.
// Sample channel in, result channel out; depends on pcfc_pkg.
`timescale 1ns / 1ps

interface pcfc_sample_if;
    import pcfc_pkg::*;

    logic  valid;
    logic  ready;
    logic  op;
    logic  vsync;
    logic  href;
    logic  pclk;
    t_byte data_byte;

    modport source (output valid, op, vsync, href, pclk, data_byte, input ready);
    modport sink   (input valid, op, vsync, href, pclk, data_byte, output ready);
endinterface

interface pcfc_result_if;
    import pcfc_pkg::*;

    logic      valid;
    logic      ready;
    t_kind     kind;
    t_pixel    pixel_value;
    t_index    pixel_index;
    t_err_code error_code;

    modport source (output valid, kind, pixel_value, pixel_index, error_code, input ready);
    modport sink   (input valid, kind, pixel_value, pixel_index, error_code, output ready);
endinterface

// ===== src/parallel_camera_frame_capture.sv =====
// Parallel camera frame capture: sample-driven phase machine, RGB565 assembly.
// Depends on pcfc_pkg and the channel interfaces in pcfc_if.sv.
//
//   channel   dir  handshake          payload
//   i_smp     in   valid/ready        op, vsync, href, pclk, data_byte
//   o_res     out  valid/ready        kind, pixel_value, pixel_index, error_code
//   i_cfg_*   in   write enable only  idx (2b), data (24b)
//
// One sample beat is taken every cycle while i_smp.ready is high; the phase
// decision for it is made in the same cycle and at most one result lands in
// the output register, which parts the two sides: a beat is taken whenever
// that register is empty or being drained, so the rate is one beat per cycle.
// Synchronous active-low reset: phase idle, counters cleared, limits to defaults.
`timescale 1ns / 1ps

module parallel_camera_frame_capture (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  pcfc_pkg::t_cfg_idx  i_cfg_idx,
    input  pcfc_pkg::t_limit    i_cfg_data,
    pcfc_sample_if.sink         i_smp,
    pcfc_result_if.source       o_res
);
    import pcfc_pkg::*;

    t_limit    r_vs_limit, r_row_limit, r_clk_limit;

    t_phase    r_phase, n_phase;
    t_byte     r_first, n_first;
    t_column   r_column, n_column;
    t_row      r_row, n_row;
    t_index    r_position, n_position;
    t_limit    r_wait, n_wait;

    logic      r_out_valid;
    t_kind     r_out_kind;
    t_pixel    r_out_pixel;
    t_index    r_out_index;
    t_err_code r_out_code;

    logic      n_valid;
    t_kind     n_kind;
    t_pixel    n_pixel;
    t_index    n_index;
    t_err_code n_code;

    logic      accept;
    logic      active;
    logic      met;
    t_limit    limit;
    t_err_code code;
    t_phase    nxt;
    t_column   col_inc;
    t_row      row_inc;

    assign i_smp.ready = !r_out_valid || o_res.ready;
    assign accept      = i_smp.valid && i_smp.ready;

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out_kind;
    assign o_res.pixel_value = r_out_pixel;
    assign o_res.pixel_index = r_out_index;
    assign o_res.error_code  = r_out_code;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs_limit  <= VSYNC_LIMIT_RST;
            r_row_limit <= ROW_LIMIT_RST;
            r_clk_limit <= CLOCK_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VSYNC_LIMIT: r_vs_limit  <= i_cfg_data;
                CFG_ROW_LIMIT:   r_row_limit <= i_cfg_data;
                CFG_CLOCK_LIMIT: r_clk_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // wait condition of the current phase
    always_comb begin
        active = 1'b1;
        met    = 1'b0;
        limit  = r_vs_limit;
        code   = ERR_VSYNC_LOW;
        nxt    = PH_IDLE;
        case (r_phase)
            PH_VS_HIGH: begin
                met = i_smp.vsync;  limit = r_vs_limit;  code = ERR_VSYNC_LOW;  nxt = PH_VS_LOW;
            end
            PH_VS_LOW: begin
                met = !i_smp.vsync; limit = r_vs_limit;  code = ERR_VSYNC_HIGH; nxt = PH_HREF_HIGH;
            end
            PH_HREF_HIGH: begin
                met = i_smp.href;   limit = r_row_limit; code = ERR_HREF_LOW;   nxt = PH_CLK_LO_A;
            end
            PH_HREF_LOW: begin
                met = !i_smp.href;  limit = r_row_limit; code = ERR_HREF_HIGH;  nxt = PH_HREF_HIGH;
            end
            PH_CLK_LO_A: begin
                met = !i_smp.pclk;  limit = r_clk_limit; code = ERR_PCLK_HIGH;  nxt = PH_CLK_HI_A;
            end
            PH_CLK_HI_A: begin
                met = i_smp.pclk;   limit = r_clk_limit; code = ERR_PCLK_LOW;   nxt = PH_CLK_LO_B;
            end
            PH_CLK_LO_B: begin
                met = !i_smp.pclk;  limit = r_clk_limit; code = ERR_PCLK_HIGH;  nxt = PH_CLK_HI_B;
            end
            PH_CLK_HI_B: begin
                met = i_smp.pclk;   limit = r_clk_limit; code = ERR_PCLK_LOW;   nxt = PH_CLK_LO_A;
            end
            default: active = 1'b0;
        endcase
    end

    assign col_inc = r_column + 8'd1;
    assign row_inc = r_row + 7'd1;

    // next state and result for one beat
    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first;
        n_column   = r_column;
        n_row      = r_row;
        n_position = r_position;
        n_wait     = r_wait;
        n_valid    = 1'b0;
        n_kind     = KIND_PIXEL;
        n_pixel    = '0;
        n_index    = '0;
        n_code     = '0;

        if (i_smp.op == OP_START) begin
            n_phase    = PH_VS_HIGH;
            n_first    = '0;
            n_column   = '0;
            n_row      = '0;
            n_position = '0;
            n_wait     = '0;
        end else if (!active) begin
            n_phase = PH_IDLE;
        end else if (!met) begin
            if (r_wait >= limit) begin
                n_phase = PH_IDLE;
                n_wait  = '0;
                n_valid = 1'b1;
                n_kind  = KIND_ERROR;
                n_code  = code;
            end else begin
                n_wait = r_wait + 24'd1;
            end
        end else begin
            n_wait = '0;
            case (r_phase)
                PH_CLK_HI_A: begin
                    n_first = i_smp.data_byte;
                    n_phase = nxt;
                end
                PH_CLK_HI_B: begin
                    n_valid    = 1'b1;
                    n_kind     = KIND_PIXEL;
                    n_pixel    = {r_first, i_smp.data_byte};
                    n_index    = r_position;
                    n_position = r_position + 15'd1;
                    // last pixel of the row hands over to the href low wait
                    if (col_inc >= t_column'(FRAME_WIDTH)) begin
                        n_column = '0;
                        n_phase  = PH_HREF_LOW;
                    end else begin
                        n_column = col_inc;
                        n_phase  = nxt;
                    end
                end
                PH_HREF_LOW: begin
                    if (row_inc >= t_row'(FRAME_HEIGHT)) begin
                        n_row   = '0;
                        n_phase = PH_IDLE;
                        n_valid = 1'b1;
                        n_kind  = KIND_DONE;
                    end else begin
                        n_row   = row_inc;
                        n_phase = nxt;
                    end
                end
                default: n_phase = nxt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_first    <= '0;
            r_column   <= '0;
            r_row      <= '0;
            r_position <= '0;
            r_wait     <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_first    <= n_first;
            r_column   <= n_column;
            r_row      <= n_row;
            r_position <= n_position;
            r_wait     <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_kind  <= n_kind;
            r_out_pixel <= n_pixel;
            r_out_index <= n_index;
            r_out_code  <= n_code;
        end
    end

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_smp.op == OP_START) |=> (r_phase == PH_VS_HIGH && r_wait == '0))
        else $error("start beat did not arm the vsync high wait");

    a_error_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_valid && n_kind == KIND_ERROR) |=> (r_phase == PH_IDLE))
        else $error("error result without return to idle");

    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column < t_column'(FRAME_WIDTH))
        else $error("column counter beyond frame width");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_PIXEL) |-> (r_out_index < t_index'(PIXELS_PER_FRAME)))
        else $error("pixel index beyond frame");

endmodule
